>>> rtl/multilevel_feedback_queue_scheduler_top_defines.svh
// assertion macros shared by the checker
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_TOP_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_TOP_DEFINES_SVH

// implication checked on every edge outside reset
`define MFQS_ASSERT_IMP(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define MFQS_ASSERT_NXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> rtl/mfqs_pkg.sv
// ----------------------------------------------------------------------------
// mfqs_pkg
// shared types and constants of the feedback-queue scheduler
// ----------------------------------------------------------------------------
package mfqs_pkg;
   localparam int SLOTS_DEF  = 16;
   localparam int LEVELS_DEF = 4;
   localparam int MODE_W     = 3;
   localparam int SLOT_W     = 4;
   localparam int LEVEL_W    = 2;

   localparam logic [MODE_W-1:0] MODE_ENQ   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PICK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TICK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BLOCK = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BOOST = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [SLOT_W-1:0]  slot;
      logic [LEVEL_W-1:0] level;
   } cmd_type;

   typedef struct packed {
      logic              accepted;
      logic [SLOT_W-1:0] picked_slot;
      logic              expired;
      logic              running;
   } rsp_type;
endpackage

>>> rtl/mfqs_cmd_queue.sv
// ----------------------------------------------------------------------------
// mfqs_cmd_queue
// two-entry queue between the command front and the scheduler core
// ----------------------------------------------------------------------------
module mfqs_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mfqs_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output mfqs_pkg::cmd_type pop_data,
   output logic             empty
);
   mfqs_pkg::cmd_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ (push && !full);
      rd_in  = rd_ff ^ (pop && !empty);
      cnt_in = cnt_ff + {1'b0, push && !full} - {1'b0, pop && !empty};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end
endmodule

>>> rtl/mfqs_core.sv
// ----------------------------------------------------------------------------
// mfqs_core
// scheduler state, level fifos and event sequencer
// ----------------------------------------------------------------------------
module mfqs_core #(
   parameter int SLOTS  = mfqs_pkg::SLOTS_DEF,
   parameter int LEVELS = mfqs_pkg::LEVELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  mfqs_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_push,
   output mfqs_pkg::rsp_type rsp,
   input  logic              rsp_full
);
   localparam int SW = $clog2(SLOTS);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int QW = LEVELS;
   localparam int AW = LW + SW;

   typedef enum logic [2:0] {S_IDLE, S_RD, S_EXEC, S_BPOP, S_BPUSH, S_OUT} state_type;

   logic [SW-1:0] fifo_mem [2**AW];
   logic [SW-1:0] rd_data_ff;
   logic [SW-1:0] head_ff  [LEVELS];
   logic [CW-1:0] count_ff [LEVELS];
   logic [LW-1:0] slevel_ff [SLOTS];
   logic [SLOTS-1:0] queued_ff;
   logic          run_valid_ff;
   logic [SW-1:0] run_slot_ff;
   logic [QW-1:0] ticks_ff;
   state_type     state_ff;
   mfqs_pkg::cmd_type cmd_ff;
   logic          acc_ff;
   logic [SW-1:0] pick_ff;
   logic          expd_ff;
   logic [LW-1:0] lv_ff;

   // lowest non-empty level
   logic          any_ne;
   logic [LW-1:0] first_ne;
   always_comb begin
      any_ne   = 1'b0;
      first_ne = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            any_ne   = 1'b1;
            first_ne = LW'(i);
         end
      end
   end

   logic          in_range;
   logic [SW-1:0] cslot;
   logic [LW-1:0] clevel;
   assign in_range = (32'(cmd_ff.slot) < SLOTS) && (32'(cmd_ff.level) < LEVELS);
   assign cslot    = SW'(cmd_ff.slot);
   assign clevel   = LW'(cmd_ff.level);

   function automatic logic [SW-1:0] tail_of(logic [SW-1:0] h, logic [CW-1:0] c);
      logic [CW:0] t;
      t = {1'b0, h} + {1'b0, c};
      if (t >= (CW+1)'(SLOTS)) t = t - (CW+1)'(SLOTS);
      return SW'(t);
   endfunction

   function automatic logic [SW-1:0] inc_head(logic [SW-1:0] h);
      return (32'(h) == SLOTS - 1) ? '0 : h + SW'(1);
   endfunction

   function automatic logic [AW-1:0] addr(logic [LW-1:0] lv, logic [SW-1:0] ix);
      return {lv, ix};
   endfunction

   logic [LW-1:0] next_lv;
   assign next_lv = (32'(slevel_ff[run_slot_ff]) >= LEVELS - 1) ? LW'(LEVELS - 1)
                    : slevel_ff[run_slot_ff] + LW'(1);

   // outcome of the current event
   logic          enq_ok, tick_exp;
   logic          acc_in, expd_in;
   logic [SW-1:0] pick_in;
   always_comb begin
      enq_ok   = in_range && count_ff[clevel] < CW'(SLOTS) && !queued_ff[cslot]
                 && !(run_valid_ff && run_slot_ff == cslot);
      tick_exp = run_valid_ff && ticks_ff <= QW'(1);
      acc_in   = 1'b0;
      pick_in  = '0;
      expd_in  = 1'b0;
      unique case (cmd_ff.mode)
         mfqs_pkg::MODE_ENQ: acc_in = enq_ok;
         mfqs_pkg::MODE_PICK: begin
            acc_in = any_ne;
            if (any_ne) pick_in = rd_data_ff;
         end
         mfqs_pkg::MODE_TICK: expd_in = tick_exp;
         default: ;
      endcase
   end

   assign cmd_pop  = state_ff == S_IDLE && cmd_valid;
   assign rsp_push = state_ff == S_OUT && !rsp_full;
   // running flag taken live so it is current when the response leaves
   assign rsp      = '{accepted: acc_ff, picked_slot: mfqs_pkg::SLOT_W'(pick_ff),
                       expired: expd_ff, running: run_valid_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         queued_ff    <= '0;
         run_valid_ff <= 1'b0;
         run_slot_ff  <= '0;
         ticks_ff     <= '0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               // registered read of the head of the lowest non-empty level
               rd_data_ff <= fifo_mem[addr(first_ne, head_ff[first_ne])];
               lv_ff      <= LW'(1);
               state_ff   <= S_EXEC;
            end
            S_EXEC: begin
               acc_ff   <= acc_in;
               pick_ff  <= pick_in;
               expd_ff  <= expd_in;
               state_ff <= (cmd_ff.mode == mfqs_pkg::MODE_BOOST) ? S_BPOP : S_OUT;
               unique case (cmd_ff.mode)
                  mfqs_pkg::MODE_ENQ: begin
                     if (enq_ok) begin
                        fifo_mem[addr(clevel, tail_of(head_ff[clevel], count_ff[clevel]))]
                           <= cslot;
                        count_ff[clevel]  <= count_ff[clevel] + CW'(1);
                        queued_ff[cslot]  <= 1'b1;
                        slevel_ff[cslot]  <= clevel;
                     end
                  end
                  mfqs_pkg::MODE_PICK: begin
                     if (any_ne) begin
                        head_ff[first_ne]     <= inc_head(head_ff[first_ne]);
                        count_ff[first_ne]    <= count_ff[first_ne] - CW'(1);
                        queued_ff[rd_data_ff] <= 1'b0;
                        run_slot_ff           <= rd_data_ff;
                        run_valid_ff          <= 1'b1;
                        ticks_ff              <= QW'(1) << first_ne;
                     end
                  end
                  mfqs_pkg::MODE_TICK: begin
                     if (run_valid_ff) begin
                        if (!tick_exp) begin
                           ticks_ff <= ticks_ff - QW'(1);
                        end else begin
                           ticks_ff <= '0;
                           fifo_mem[addr(next_lv,
                                         tail_of(head_ff[next_lv], count_ff[next_lv]))]
                              <= run_slot_ff;
                           count_ff[next_lv]      <= count_ff[next_lv] + CW'(1);
                           queued_ff[run_slot_ff] <= 1'b1;
                           slevel_ff[run_slot_ff] <= next_lv;
                           run_valid_ff           <= 1'b0;
                        end
                     end
                  end
                  mfqs_pkg::MODE_BLOCK: begin
                     run_valid_ff <= 1'b0;
                     ticks_ff     <= '0;
                  end
                  default: ;
               endcase
            end
            S_BPOP: begin
               if (count_ff[lv_ff] != '0) begin
                  rd_data_ff <= fifo_mem[addr(lv_ff, head_ff[lv_ff])];
                  state_ff   <= S_BPUSH;
               end else if (32'(lv_ff) == LEVELS - 1) begin
                  state_ff <= S_OUT;
               end else begin
                  lv_ff <= lv_ff + LW'(1);
               end
            end
            S_BPUSH: begin
               // slot stays queued, only its level changes
               head_ff[lv_ff]  <= inc_head(head_ff[lv_ff]);
               count_ff[lv_ff] <= count_ff[lv_ff] - CW'(1);
               fifo_mem[addr(LW'(0), tail_of(head_ff[0], count_ff[0]))] <= rd_data_ff;
               count_ff[0]     <= count_ff[0] + CW'(1);
               slevel_ff[rd_data_ff] <= '0;
               state_ff        <= S_BPOP;
            end
            S_OUT: begin
               if (!rsp_full) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> rtl/mfqs_rsp_queue.sv
// ----------------------------------------------------------------------------
// mfqs_rsp_queue
// two-entry result queue driving the response ports
// ----------------------------------------------------------------------------
module mfqs_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mfqs_pkg::rsp_type push_data,
   output logic              full,
   input  logic              pop,
   output mfqs_pkg::rsp_type pop_data,
   output logic              empty
);
   mfqs_pkg::rsp_type mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_ff ^ (push && !full);
         rd_ff  <= rd_ff ^ (pop && !empty);
         cnt_ff <= cnt_ff + {1'b0, push && !full} - {1'b0, pop && !empty};
      end
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end
endmodule

>>> rtl/multilevel_feedback_queue_scheduler_top.sv
// an accepted event passes core states S_RD, S_EXEC and S_OUT, then enters the result queue;
// a boost adds S_BPOP and S_BPUSH per moved entry plus S_BPOP per empty level from 1 up
// the core takes one event at a time; S_OUT is left only when the result queue is not full
// the level fifo memory port (one access per cycle) sets the boost length
// reset: synchronous active high, clears queues, counters and run state
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler_top
// four-level feedback-queue scheduler with command and result queues
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler_top #(
   parameter int SLOTS  = mfqs_pkg::SLOTS_DEF,
   parameter int LEVELS = mfqs_pkg::LEVELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [2:0] req_mode,
   input  logic [3:0] req_slot,
   input  logic [1:0] req_level,
   output logic       empty,
   input  logic       pop,
   output logic       rsp_accepted,
   output logic [3:0] rsp_picked_slot,
   output logic       rsp_expired,
   output logic       rsp_running
);
   mfqs_pkg::cmd_type in_cmd, q_cmd;
   mfqs_pkg::rsp_type c_rsp, o_rsp;
   logic q_empty, q_pop, r_push, r_full;

   assign in_cmd = '{mode: req_mode, slot: req_slot, level: req_level};

   mfqs_cmd_queue u_cmdq (
      .clock, .reset, .push, .push_data(in_cmd), .full,
      .pop(q_pop), .pop_data(q_cmd), .empty(q_empty)
   );

   mfqs_core #(.SLOTS(SLOTS), .LEVELS(LEVELS)) u_core (
      .clock, .reset, .cmd_valid(!q_empty), .cmd(q_cmd), .cmd_pop(q_pop),
      .rsp_push(r_push), .rsp(c_rsp), .rsp_full(r_full)
   );

   mfqs_rsp_queue u_rspq (
      .clock, .reset, .push(r_push), .push_data(c_rsp), .full(r_full),
      .pop, .pop_data(o_rsp), .empty
   );

   assign rsp_accepted    = o_rsp.accepted;
   assign rsp_picked_slot = o_rsp.picked_slot;
   assign rsp_expired     = o_rsp.expired;
   assign rsp_running     = o_rsp.running;
endmodule

>>> rtl/mfqs_checker.sv
// ----------------------------------------------------------------------------
// mfqs_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`include "multilevel_feedback_queue_scheduler_top_defines.svh"

module mfqs_checker (
   input logic       clock,
   input logic       reset,
   input logic       empty,
   input logic       pop,
   input logic       rsp_accepted,
   input logic [3:0] rsp_picked_slot,
   input logic       rsp_expired,
   input logic       rsp_running
);
   `MFQS_ASSERT_IMP(a_exp_idle, clock, reset, !empty && rsp_expired, !rsp_running, "expired while running")
   `MFQS_ASSERT_IMP(a_exp_acc, clock, reset, !empty && rsp_expired, !rsp_accepted, "expired and accepted")
   `MFQS_ASSERT_NXT(a_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_picked_slot), "result dropped")
endmodule

bind multilevel_feedback_queue_scheduler_top mfqs_checker u_chk (
   .clock, .reset, .empty, .pop, .rsp_accepted, .rsp_picked_slot, .rsp_expired, .rsp_running
);
